// ===== rtl/sti_pkg.sv =====
// ----------------------------------------------------------------------------
// sti_pkg
// Shared widths, types and helpers for the segment/triangle intersection pipe.
// ----------------------------------------------------------------------------
package sti_pkg;

    localparam int CW    = 21;              // coordinate width (Q12.8)
    localparam int PTW   = 3 * CW;          // packed point width
    localparam int DW    = CW + 1;          // coordinate difference
    localparam int NW    = 2 * DW + 1;      // normal component
    localparam int RW    = 69;              // plane distance r1, r2
    localparam int DENW  = RW + 1;          // r1 - r2
    localparam int D2W   = DENW + 1;        // 2 * (r1 - r2)
    localparam int RLO   = 35;              // low split of r1 for the multiply
    localparam int QW    = CW;              // quotient bits
    localparam int NUMW  = 93;              // rounding numerator
    localparam int WW    = 68;              // edge normal N x side
    localparam int WLW   = WW / 2;          // low split of the edge normal
    localparam int RLW   = CW + 2;          // point relative to a vertex
    localparam int EW    = 93;              // edge test dot product

    typedef logic signed [CW-1:0]   t_crd;
    typedef logic signed [DW-1:0]   t_dif;
    typedef logic signed [NW-1:0]   t_nrm;
    typedef logic signed [RW-1:0]   t_r;
    typedef logic signed [WW-1:0]   t_w;
    typedef logic signed [RLW-1:0]  t_rel;
    typedef logic [DENW-1:0]        t_den;
    typedef logic [D2W-1:0]         t_den2;
    typedef logic [NUMW-1:0]        t_num;
    typedef logic [QW-1:0]          t_q;

    // Per-request context that rides along the divider.
    typedef struct packed {
        logic                   mode;
        logic                   ok;     // crosses front to back, not coplanar
        t_crd [2:0]             s;      // segment start
        logic [2:0]             neg;    // end - start is negative per axis
        t_dif [2:0][2:0]        sv;     // start minus vertex i, per axis
        t_w   [2:0][2:0]        w;      // N x side i
    } t_ctx;

    function automatic t_crd crd(input logic [PTW-1:0] pt, input logic [1:0] idx);
        return t_crd'(pt[idx*CW +: CW]);
    endfunction

endpackage

// ===== rtl/segment_triangle_intersect.sv =====
// Pipeline: front, divide and edge/result sections from request accept to
//   result valid; an output stall freezes them. Throughput: one request
//   per cycle unless the output stalls; the 21-stage divider is the depth.
// Reset: i_rst_n synchronous active low clears all valid bits; payload
//   registers are not reset.
// ----------------------------------------------------------------------------
// segment_triangle_intersect
// Streaming segment/triangle intersection in exact integer arithmetic.
// ----------------------------------------------------------------------------
module segment_triangle_intersect (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [62:0] seg_start, [125:63] seg_end, [188:126] vert_a,
    // [251:189] vert_b, [314:252] vert_c, [319:315] zero
    input  logic [319:0] s_axis_tdata,
    // [0] mode
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [20:0] point_x, [41:21] point_y, [62:42] point_z, [63] zero
    output logic [63:0]  m_axis_tdata,
    // [0] hit
    output logic         m_axis_tuser
);

    // Single pipeline enable: every stage moves when the output register is
    // empty or being drained. Valid bits travel with the data, so bubbles
    // simply flow through and a stall freezes everything in place.
    logic                   w_en;
    logic                   w_f_vld, w_d_vld, w_e_vld, w_hit;
    sti_pkg::t_num [2:0]    w_num;
    sti_pkg::t_den2         w_den2;
    sti_pkg::t_ctx          w_f_ctx, w_d_ctx;
    sti_pkg::t_q   [2:0]    w_q;
    sti_pkg::t_crd [2:0]    w_point;

    assign w_en          = !w_e_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    // Normal, plane distances r1/r2, front-to-back test, rounding numerator.
    sti_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_vld       (s_axis_tvalid),
        .i_mode      (s_axis_tuser),
        .i_seg_start (s_axis_tdata[62:0]),
        .i_seg_end   (s_axis_tdata[125:63]),
        .i_vert_a    (s_axis_tdata[188:126]),
        .i_vert_b    (s_axis_tdata[251:189]),
        .i_vert_c    (s_axis_tdata[314:252]),
        .o_vld       (w_f_vld),
        .o_num       (w_num),
        .o_den2      (w_den2),
        .o_ctx       (w_f_ctx)
    );

    // q = round(|delta| * r1 / (r1 - r2)) per axis, ties away from zero.
    sti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_f_vld),
        .i_num   (w_num),
        .i_den2  (w_den2),
        .i_ctx   (w_f_ctx),
        .o_vld   (w_d_vld),
        .o_q     (w_q),
        .o_ctx   (w_d_ctx)
    );

    // Crossing point, three inside-edge tests, output register.
    sti_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_d_vld),
        .i_q     (w_q),
        .i_ctx   (w_d_ctx),
        .o_vld   (w_e_vld),
        .o_hit   (w_hit),
        .o_point (w_point)
    );

    assign m_axis_tvalid = w_e_vld;
    assign m_axis_tuser  = w_hit;
    assign m_axis_tdata  = {1'b0, w_point[2], w_point[1], w_point[0]};

`ifndef SYNTHESIS
    // a miss always carries a zero point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("miss with nonzero point");

    // a blocked result must back-pressure the input side
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

// ===== rtl/sti_front.sv =====
// ----------------------------------------------------------------------------
// sti_front
// Six stages: edges, normal, plane distances, edge normals and the rounding
// numerator for the crossing point.
// ----------------------------------------------------------------------------
module sti_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic                    i_mode,
    input  logic [sti_pkg::PTW-1:0] i_seg_start,
    input  logic [sti_pkg::PTW-1:0] i_seg_end,
    input  logic [sti_pkg::PTW-1:0] i_vert_a,
    input  logic [sti_pkg::PTW-1:0] i_vert_b,
    input  logic [sti_pkg::PTW-1:0] i_vert_c,
    output logic                    o_vld,
    output sti_pkg::t_num [2:0]     o_num,
    output sti_pkg::t_den2          o_den2,
    output sti_pkg::t_ctx           o_ctx
);

    localparam int PLW = sti_pkg::RLO + sti_pkg::DW;
    localparam int PHW = sti_pkg::RW - sti_pkg::RLO + sti_pkg::DW;

    logic [5:0] r_vld;

    // stage 1
    sti_pkg::t_dif [2:0][2:0] r1_side, n1_side, r1_sv, n1_sv;
    sti_pkg::t_dif [2:0]      r1_d0, n1_d0, r1_d1, n1_d1, r1_dl, n1_dl;
    sti_pkg::t_crd [2:0]      r1_s, n1_s;
    logic                     r1_mode;
    // stage 2
    sti_pkg::t_nrm [2:0]      r2_n, n2_n;
    sti_pkg::t_dif [2:0][2:0] r2_side, r2_sv;
    sti_pkg::t_dif [2:0]      r2_d0, r2_d1, r2_dl;
    sti_pkg::t_crd [2:0]      r2_s;
    logic                     r2_mode;
    // stage 3
    sti_pkg::t_r   [2:0]      r3_p0, n3_p0, r3_p1, n3_p1;
    sti_pkg::t_w   [2:0][2:0] r3_wa, n3_wa, r3_wb, n3_wb;
    sti_pkg::t_dif [2:0][2:0] r3_sv;
    sti_pkg::t_dif [2:0]      r3_dl;
    sti_pkg::t_crd [2:0]      r3_s;
    logic                     r3_mode;
    // stage 4
    sti_pkg::t_r              r4_r1, n4_r1, r4_r2, n4_r2;
    sti_pkg::t_w   [2:0][2:0] r4_w, n4_w;
    sti_pkg::t_dif [2:0][2:0] r4_sv;
    sti_pkg::t_dif [2:0]      r4_dl;
    sti_pkg::t_crd [2:0]      r4_s;
    logic                     r4_mode;
    // stage 5
    logic                     r5_ok, n5_ok;
    sti_pkg::t_den            r5_den, n5_den;
    logic [PLW-1:0]           r5_plo [3];
    logic [PLW-1:0]           n5_plo [3];
    logic [PHW-1:0]           r5_phi [3];
    logic [PHW-1:0]           n5_phi [3];
    logic [2:0]               r5_neg, n5_neg;
    sti_pkg::t_w   [2:0][2:0] r5_w;
    sti_pkg::t_dif [2:0][2:0] r5_sv;
    sti_pkg::t_crd [2:0]      r5_s;
    logic                     r5_mode;
    // stage 6
    sti_pkg::t_num [2:0]      r6_num, n6_num;
    sti_pkg::t_den2           r6_den2;
    sti_pkg::t_ctx            r6_ctx;

    function automatic sti_pkg::t_nrm mul_d(input sti_pkg::t_dif a, input sti_pkg::t_dif b);
        return sti_pkg::t_nrm'(a) * sti_pkg::t_nrm'(b);
    endfunction

    function automatic sti_pkg::t_w mul_nd(input sti_pkg::t_nrm a, input sti_pkg::t_dif b);
        return sti_pkg::t_w'(a) * sti_pkg::t_w'(b);
    endfunction

    function automatic sti_pkg::t_dif dif(input sti_pkg::t_crd a, input sti_pkg::t_crd b);
        return sti_pkg::t_dif'(a) - sti_pkg::t_dif'(b);
    endfunction

    // stage 1: unpack and take differences
    always_comb begin
        sti_pkg::t_crd s, e, a, b, c;
        for (int k = 0; k < 3; k++) begin
            s = sti_pkg::crd(i_seg_start, 2'(k));
            e = sti_pkg::crd(i_seg_end, 2'(k));
            a = sti_pkg::crd(i_vert_a, 2'(k));
            b = sti_pkg::crd(i_vert_b, 2'(k));
            c = sti_pkg::crd(i_vert_c, 2'(k));
            n1_side[0][k] = dif(b, a);
            n1_side[1][k] = dif(c, b);
            n1_side[2][k] = dif(a, c);
            n1_sv[0][k]   = dif(s, a);
            n1_sv[1][k]   = dif(s, b);
            n1_sv[2][k]   = dif(s, c);
            n1_d0[k]      = dif(s, a);
            n1_d1[k]      = dif(e, a);
            n1_dl[k]      = dif(e, s);
            n1_s[k]       = s;
        end
    end

    // stage 2: normal N = side0 x side1
    always_comb begin
        n2_n[0] = mul_d(r1_side[0][1], r1_side[1][2]) - mul_d(r1_side[0][2], r1_side[1][1]);
        n2_n[1] = mul_d(r1_side[0][2], r1_side[1][0]) - mul_d(r1_side[0][0], r1_side[1][2]);
        n2_n[2] = mul_d(r1_side[0][0], r1_side[1][1]) - mul_d(r1_side[0][1], r1_side[1][0]);
    end

    // stage 3: distance products and edge normal products
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n3_p0[k] = sti_pkg::t_r'(mul_nd(r2_n[k], r2_d0[k]));
            n3_p1[k] = sti_pkg::t_r'(mul_nd(r2_n[k], r2_d1[k]));
        end
        for (int i = 0; i < 3; i++) begin
            n3_wa[i][0] = mul_nd(r2_n[1], r2_side[i][2]);
            n3_wb[i][0] = mul_nd(r2_n[2], r2_side[i][1]);
            n3_wa[i][1] = mul_nd(r2_n[2], r2_side[i][0]);
            n3_wb[i][1] = mul_nd(r2_n[0], r2_side[i][2]);
            n3_wa[i][2] = mul_nd(r2_n[0], r2_side[i][1]);
            n3_wb[i][2] = mul_nd(r2_n[1], r2_side[i][0]);
        end
    end

    // stage 4: sums
    always_comb begin
        n4_r1 = r3_p0[0] + r3_p0[1] + r3_p0[2];
        n4_r2 = r3_p1[0] + r3_p1[1] + r3_p1[2];
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                n4_w[i][k] = r3_wa[i][k] - r3_wb[i][k];
            end
        end
    end

    // stage 5: side test, denominator, r1 * |delta| partial products
    always_comb begin
        logic [sti_pkg::DW-1:0] mag;
        n5_ok  = !r4_r1[sti_pkg::RW-1] && (r4_r2[sti_pkg::RW-1] || (r4_r2 == '0))
                 && (r4_r1 != r4_r2);
        n5_den = sti_pkg::t_den'(sti_pkg::DENW'(r4_r1) - sti_pkg::DENW'(r4_r2));
        for (int k = 0; k < 3; k++) begin
            n5_neg[k] = r4_dl[k][sti_pkg::DW-1];
            mag       = n5_neg[k] ? sti_pkg::DW'(-r4_dl[k]) : sti_pkg::DW'(r4_dl[k]);
            n5_plo[k] = PLW'(r4_r1[sti_pkg::RLO-1:0]) * PLW'(mag);
            n5_phi[k] = PHW'(r4_r1[sti_pkg::RW-1:sti_pkg::RLO]) * PHW'(mag);
        end
    end

    // stage 6: num = 2 * r1 * |delta| + den
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n6_num[k] = (((sti_pkg::NUMW'(r5_phi[k]) << sti_pkg::RLO)
                          + sti_pkg::NUMW'(r5_plo[k])) << 1) + sti_pkg::NUMW'(r5_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= n1_side;  r1_sv <= n1_sv;  r1_d0 <= n1_d0;  r1_d1 <= n1_d1;
            r1_dl   <= n1_dl;    r1_s  <= n1_s;   r1_mode <= i_mode;

            r2_n    <= n2_n;     r2_side <= r1_side;  r2_sv <= r1_sv;
            r2_d0   <= r1_d0;    r2_d1 <= r1_d1;  r2_dl <= r1_dl;
            r2_s    <= r1_s;     r2_mode <= r1_mode;

            r3_p0   <= n3_p0;    r3_p1 <= n3_p1;  r3_wa <= n3_wa;  r3_wb <= n3_wb;
            r3_sv   <= r2_sv;    r3_dl <= r2_dl;  r3_s <= r2_s;    r3_mode <= r2_mode;

            r4_r1   <= n4_r1;    r4_r2 <= n4_r2;  r4_w <= n4_w;
            r4_sv   <= r3_sv;    r4_dl <= r3_dl;  r4_s <= r3_s;    r4_mode <= r3_mode;

            r5_ok   <= n5_ok;    r5_den <= n5_den;  r5_plo <= n5_plo;  r5_phi <= n5_phi;
            r5_neg  <= n5_neg;   r5_w <= r4_w;    r5_sv <= r4_sv;
            r5_s    <= r4_s;     r5_mode <= r4_mode;

            r6_num      <= n6_num;
            r6_den2     <= {r5_den, 1'b0};
            r6_ctx.mode <= r5_mode;
            r6_ctx.ok   <= r5_ok;
            r6_ctx.s    <= r5_s;
            r6_ctx.neg  <= r5_neg;
            r6_ctx.sv   <= r5_sv;
            r6_ctx.w    <= r5_w;
        end
    end

    assign o_vld  = r_vld[5];
    assign o_num  = r6_num;
    assign o_den2 = r6_den2;
    assign o_ctx  = r6_ctx;

endmodule

// ===== rtl/sti_div.sv =====
// ----------------------------------------------------------------------------
// sti_div
// Pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor.
// ----------------------------------------------------------------------------
module sti_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  sti_pkg::t_num [2:0] i_num,
    input  sti_pkg::t_den2      i_den2,
    input  sti_pkg::t_ctx       i_ctx,
    output logic                o_vld,
    output sti_pkg::t_q [2:0]   o_q,
    output sti_pkg::t_ctx       o_ctx
);

    localparam int NS = sti_pkg::QW;

    logic [NS-1:0]           r_vld;
    sti_pkg::t_num [2:0]     r_rem  [NS];
    sti_pkg::t_num [2:0]     n_rem  [NS];
    sti_pkg::t_q   [2:0]     r_q    [NS];
    sti_pkg::t_q   [2:0]     n_q    [NS];
    sti_pkg::t_den2          r_den2 [NS];
    sti_pkg::t_ctx           r_ctx  [NS];

    // stage j decides quotient bit NS-1-j
    always_comb begin
        sti_pkg::t_num            src;
        sti_pkg::t_num            dsh;
        sti_pkg::t_q              qsrc;
        sti_pkg::t_den2           dsrc;
        logic [sti_pkg::NUMW:0]   trial;
        for (int j = 0; j < NS; j++) begin
            dsrc = (j == 0) ? i_den2 : r_den2[(j == 0) ? 0 : j - 1];
            for (int l = 0; l < 3; l++) begin
                src   = (j == 0) ? i_num[l] : r_rem[(j == 0) ? 0 : j - 1][l];
                qsrc  = (j == 0) ? '0 : r_q[(j == 0) ? 0 : j - 1][l];
                dsh   = sti_pkg::NUMW'(dsrc) << (NS - 1 - j);
                trial = {1'b0, src} - {1'b0, dsh};
                if (!trial[sti_pkg::NUMW]) begin
                    n_rem[j][l] = trial[sti_pkg::NUMW-1:0];
                    n_q[j][l]   = qsrc | (sti_pkg::t_q'(1) << (NS - 1 - j));
                end else begin
                    n_rem[j][l] = src;
                    n_q[j][l]   = qsrc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NS; j++) begin
                r_rem[j]  <= n_rem[j];
                r_q[j]    <= n_q[j];
                r_den2[j] <= (j == 0) ? i_den2 : r_den2[(j == 0) ? 0 : j - 1];
                r_ctx[j]  <= (j == 0) ? i_ctx : r_ctx[(j == 0) ? 0 : j - 1];
            end
        end
    end

    assign o_vld = r_vld[NS-1];
    assign o_q   = r_q[NS-1];
    assign o_ctx = r_ctx[NS-1];

endmodule

// ===== rtl/sti_edge.sv =====
// ----------------------------------------------------------------------------
// sti_edge
// Crossing point, inside-edge tests and the registered result.
// ----------------------------------------------------------------------------
module sti_edge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  sti_pkg::t_q [2:0]   i_q,
    input  sti_pkg::t_ctx       i_ctx,
    output logic                o_vld,
    output logic                o_hit,
    output sti_pkg::t_crd [2:0] o_point
);

    localparam int LOW = sti_pkg::WLW + 1 + sti_pkg::RLW;
    localparam int HIW = sti_pkg::WW - sti_pkg::WLW + sti_pkg::RLW;

    typedef logic signed [LOW-1:0]         t_plo;
    typedef logic signed [HIW-1:0]         t_phi;
    typedef logic signed [sti_pkg::EW-1:0] t_edot;

    logic [3:0] r_vld;

    // stage 1
    sti_pkg::t_rel [2:0]      r1_p, n1_p;
    sti_pkg::t_rel [2:0][2:0] r1_rel, n1_rel;
    sti_pkg::t_w   [2:0][2:0] r1_w;
    logic                     r1_mode, r1_ok;
    // stage 2
    t_plo [2:0][2:0]          r2_plo, n2_plo;
    t_phi [2:0][2:0]          r2_phi, n2_phi;
    sti_pkg::t_rel [2:0]      r2_p;
    logic                     r2_mode, r2_ok;
    // stage 3
    logic [2:0]               r3_in, n3_in;
    sti_pkg::t_rel [2:0]      r3_p;
    logic                     r3_mode, r3_ok;
    // stage 4 (output)
    logic                     r_hit, n_hit;
    sti_pkg::t_crd [2:0]      r_point, n_point;

    function automatic sti_pkg::t_crd sat(input sti_pkg::t_rel v);
        sti_pkg::t_rel hi;
        sti_pkg::t_rel lo;
        hi = sti_pkg::t_rel'({1'b0, {(sti_pkg::CW-1){1'b1}}});
        lo = -hi - sti_pkg::t_rel'(1);
        if (v > hi) begin
            return sti_pkg::t_crd'(hi);
        end else if (v < lo) begin
            return sti_pkg::t_crd'(lo);
        end
        return sti_pkg::t_crd'(v);
    endfunction

    // stage 1: P = S +/- q, rel_i = P - V_i
    always_comb begin
        sti_pkg::t_rel sq;
        for (int k = 0; k < 3; k++) begin
            sq = sti_pkg::t_rel'({2'b00, i_q[k]});
            if (i_ctx.neg[k]) begin
                sq = -sq;
            end
            n1_p[k] = sti_pkg::t_rel'(i_ctx.s[k]) + sq;
            for (int i = 0; i < 3; i++) begin
                n1_rel[i][k] = sti_pkg::t_rel'(i_ctx.sv[i][k]) + sq;
            end
        end
    end

    // stage 2: split products of (N x side_i) . rel_i
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                n2_plo[i][k] = t_plo'($signed({1'b0, r1_w[i][k][sti_pkg::WLW-1:0]}))
                               * t_plo'(r1_rel[i][k]);
                n2_phi[i][k] = t_phi'($signed(r1_w[i][k][sti_pkg::WW-1:sti_pkg::WLW]))
                               * t_phi'(r1_rel[i][k]);
            end
        end
    end

    // stage 3: edge sums, keep the sign only
    always_comb begin
        t_edot acc;
        for (int i = 0; i < 3; i++) begin
            acc = '0;
            for (int k = 0; k < 3; k++) begin
                acc = acc + (t_edot'(r2_phi[i][k]) <<< sti_pkg::WLW) + t_edot'(r2_plo[i][k]);
            end
            n3_in[i] = !acc[sti_pkg::EW-1];
        end
    end

    // stage 4: result
    always_comb begin
        n_hit = r3_ok && (r3_mode || (&r3_in));
        for (int k = 0; k < 3; k++) begin
            n_point[k] = n_hit ? sat(r3_p[k]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p    <= n1_p;    r1_rel <= n1_rel;  r1_w <= i_ctx.w;
            r1_mode <= i_ctx.mode;  r1_ok <= i_ctx.ok;

            r2_plo  <= n2_plo;  r2_phi <= n2_phi;  r2_p <= r1_p;
            r2_mode <= r1_mode; r2_ok <= r1_ok;

            r3_in   <= n3_in;   r3_p <= r2_p;  r3_mode <= r2_mode;  r3_ok <= r2_ok;

            r_hit   <= n_hit;   r_point <= n_point;
        end
    end

    assign o_vld   = r_vld[3];
    assign o_hit   = r_hit;
    assign o_point = r_point;

endmodule
